/* hdl/bmf_pkg.sv */
package bmf_pkg;

    localparam int DEF_MAX_KERNEL = 7;
    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_HEIGHT = 1024;

    localparam int PIX_W      = 8;
    localparam int KSIZE_W    = 3;
    localparam int CFG_DIM_W  = 11;
    localparam int CFG_DATA_W = 11;
    localparam int CFG_IDX_W  = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_SIZE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd2;

    localparam logic [KSIZE_W-1:0]   KSIZE_RESET  = 3'd3;
    localparam logic [CFG_DIM_W-1:0] WIDTH_RESET  = 11'd1024;
    localparam logic [CFG_DIM_W-1:0] HEIGHT_RESET = 11'd1024;

    localparam logic REQ_PIXEL = 1'b0;
    localparam logic REQ_DRAIN = 1'b1;

    typedef struct packed {
        logic               req_type;
        logic [PIX_W-1:0]   pixel;
    } req_t;

    typedef struct packed {
        logic [KSIZE_W-1:0]   kernel_size;
        logic [CFG_DIM_W-1:0] frame_width;
        logic [CFG_DIM_W-1:0] frame_height;
    } cfg_t;

endpackage

/* hdl/bmf_front.sv */
module bmf_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_stall,
    input  bmf_pkg::req_t in_req,
    output logic          q_valid,
    output bmf_pkg::req_t q_head,
    input  logic          q_pop
);
    import bmf_pkg::*;

    // Two-entry request queue between the input port and the engine.
    req_t        slot_reg [2];
    logic        wr_ptr_reg;
    logic        rd_ptr_reg;
    logic [1:0]  count_reg;
    logic [1:0]  count_next;
    logic        push;
    logic        pop;

    assign in_stall = (count_reg == 2'd2);
    assign push     = in_valid && !in_stall;
    assign q_valid  = (count_reg != 2'd0);
    assign pop      = q_pop && q_valid;
    assign q_head   = slot_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= in_req;
        end
    end

endmodule

/* hdl/bmf_back.sv */
module bmf_back #(
    parameter int MAX_KERNEL = bmf_pkg::DEF_MAX_KERNEL,
    parameter int MAX_WIDTH  = bmf_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = bmf_pkg::DEF_MAX_HEIGHT
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  bmf_pkg::cfg_t              cfg,
    input  logic                       q_valid,
    input  bmf_pkg::req_t              q_head,
    output logic                       q_pop,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic [bmf_pkg::PIX_W-1:0]  mean_pixel,
    output logic                       frame_last
);
    import bmf_pkg::*;

    localparam int LR       = MAX_KERNEL + 1;
    localparam int RING_W   = $clog2(LR);
    localparam int COL_W    = $clog2(MAX_WIDTH);
    localparam int DIM_W    = $clog2(MAX_WIDTH + 1);
    localparam int HDIM_W   = $clog2(MAX_HEIGHT + 1);
    localparam int MAX_HALF = (MAX_KERNEL - 1) / 2;
    localparam int HALF_W   = $clog2(MAX_HALF + 2);
    localparam int OFF_W    = $clog2(2 * MAX_HALF + 2);
    localparam int SUM_W    = $clog2(MAX_KERNEL * MAX_KERNEL * 255 + 1);
    localparam int DIVR_W   = $clog2((2 * MAX_HALF + 1) * (2 * MAX_HALF + 1) + 1);
    localparam int STEP_W   = $clog2(SUM_W + 1);
    localparam int DEPTH    = LR * MAX_WIDTH;
    localparam int ADDR_W   = $clog2(DEPTH);

    typedef enum logic [2:0] {ST_IDLE, ST_CHECK, ST_READ, ST_DRAIN, ST_DIV} state_t;

    state_t               state_reg;
    logic [DIM_W-1:0]     cur_w_reg;
    logic [HDIM_W-1:0]    cur_h_reg;
    logic [HALF_W-1:0]    cur_half_reg;
    logic [DIVR_W-1:0]    cur_div_reg;
    logic [COL_W-1:0]     tcol_reg;
    logic [HDIM_W-1:0]    trow_reg;
    logic [RING_W-1:0]    tring_reg;
    logic [COL_W-1:0]     gcol_reg;
    logic [HDIM_W-1:0]    grow_reg;
    logic [RING_W-1:0]    gring_reg;
    logic [OFF_W-1:0]     di_reg;
    logic [OFF_W-1:0]     dj_reg;
    logic [RING_W-1:0]    rring_reg;
    logic                 rd_vld_reg;
    logic                 rd_ok_reg;
    logic [SUM_W-1:0]     acc_reg;
    logic [DIVR_W:0]      rem_reg;
    logic [STEP_W-1:0]    step_reg;
    logic                 out_valid_reg;
    logic [PIX_W-1:0]     mean_reg;
    logic                 last_reg;
    logic [PIX_W-1:0]     mem [DEPTH];
    logic [PIX_W-1:0]     rd_data_reg;

    // Effective frame settings: sampled from the registers at frame start.
    logic                 frame_start;
    logic [DIM_W-1:0]     eff_w;
    logic [HDIM_W-1:0]    eff_h;
    logic [HALF_W-1:0]    eff_half;
    logic [HALF_W-1:0]    cfg_half;
    logic [OFF_W-1:0]     eff_side;
    logic [DIM_W-1:0]     cfg_w;
    logic [HDIM_W-1:0]    cfg_h;

    always_comb
    begin
        if (cfg.frame_width == '0)
            cfg_w = DIM_W'(1);
        else if (32'(cfg.frame_width) > 32'(MAX_WIDTH))
            cfg_w = DIM_W'(MAX_WIDTH);
        else
            cfg_w = DIM_W'(cfg.frame_width);
        if (cfg.frame_height == '0)
            cfg_h = HDIM_W'(1);
        else if (32'(cfg.frame_height) > 32'(MAX_HEIGHT))
            cfg_h = HDIM_W'(MAX_HEIGHT);
        else
            cfg_h = HDIM_W'(cfg.frame_height);
        if (32'(cfg.kernel_size[KSIZE_W-1:1]) > 32'(MAX_HALF))
            cfg_half = HALF_W'(MAX_HALF);
        else
            cfg_half = HALF_W'(cfg.kernel_size[KSIZE_W-1:1]);
    end

    assign frame_start = (tcol_reg == '0) && (trow_reg == '0) &&
                         (gcol_reg == '0) && (grow_reg == '0);
    assign eff_w    = frame_start ? cfg_w : cur_w_reg;
    assign eff_h    = frame_start ? cfg_h : cur_h_reg;
    assign eff_half = frame_start ? cfg_half : cur_half_reg;
    assign eff_side = OFF_W'({eff_half, 1'b1});

    logic pop;
    logic do_write;
    assign pop      = (state_reg == ST_IDLE) && q_valid && !out_valid_reg;
    assign q_pop    = pop;
    assign do_write = pop && (q_head.req_type == REQ_PIXEL) && (trow_reg < eff_h);

    // Output readiness: every in-frame neighbor has arrived.
    logic [HDIM_W:0]  pr_sum;
    logic [HDIM_W:0]  pr;
    logic [DIM_W:0]   pc_sum;
    logic [DIM_W:0]   pc;
    logic             emit;
    logic             is_last;

    always_comb
    begin
        pr_sum = (HDIM_W+1)'(grow_reg) + (HDIM_W+1)'(cur_half_reg);
        pr     = (pr_sum > (HDIM_W+1)'(cur_h_reg - 1'b1)) ?
                 (HDIM_W+1)'(cur_h_reg - 1'b1) : pr_sum;
        pc_sum = (DIM_W+1)'(gcol_reg) + (DIM_W+1)'(cur_half_reg);
        pc     = (pc_sum > (DIM_W+1)'(cur_w_reg - 1'b1)) ?
                 (DIM_W+1)'(cur_w_reg - 1'b1) : pc_sum;
        emit   = ((HDIM_W+1)'(trow_reg) > pr) ||
                 (((HDIM_W+1)'(trow_reg) == pr) && ((DIM_W+1)'(tcol_reg) > pc));
        is_last = ((HDIM_W+1)'(grow_reg) == (HDIM_W+1)'(cur_h_reg - 1'b1)) &&
                  ((DIM_W+1)'(gcol_reg) == (DIM_W+1)'(cur_w_reg - 1'b1));
    end

    // Window read address for the current offset.
    logic [HDIM_W:0]  rsum;
    logic [DIM_W:0]   csum;
    logic             nb_ok;
    logic [COL_W-1:0] nb_col;
    logic [ADDR_W-1:0] rd_addr;
    logic [ADDR_W-1:0] wr_addr;
    logic [OFF_W-1:0]  side_m1;
    logic [RING_W:0]   ring_start;

    always_comb
    begin
        rsum    = (HDIM_W+1)'(grow_reg) + (HDIM_W+1)'(di_reg);
        csum    = (DIM_W+1)'(gcol_reg) + (DIM_W+1)'(dj_reg);
        nb_ok   = (rsum >= (HDIM_W+1)'(cur_half_reg)) &&
                  (rsum < (HDIM_W+1)'(cur_h_reg) + (HDIM_W+1)'(cur_half_reg)) &&
                  (csum >= (DIM_W+1)'(cur_half_reg)) &&
                  (csum < (DIM_W+1)'(cur_w_reg) + (DIM_W+1)'(cur_half_reg));
        nb_col  = COL_W'(csum - (DIM_W+1)'(cur_half_reg));
        rd_addr = nb_ok ? ADDR_W'(32'(rring_reg) * MAX_WIDTH + 32'(nb_col)) : '0;
        wr_addr = ADDR_W'(32'(tring_reg) * MAX_WIDTH + 32'(tcol_reg));
        side_m1 = OFF_W'({cur_half_reg, 1'b0});
        if ((RING_W+1)'(gring_reg) >= (RING_W+1)'(cur_half_reg))
            ring_start = (RING_W+1)'(gring_reg) - (RING_W+1)'(cur_half_reg);
        else
            ring_start = (RING_W+1)'(gring_reg) + (RING_W+1)'(LR) -
                         (RING_W+1)'(cur_half_reg);
    end

    logic [DIVR_W:0] shifted;
    assign shifted = {rem_reg[DIVR_W-1:0], acc_reg[SUM_W-1]};

    always_ff @(posedge clk)
    begin
        if (do_write)
        begin
            mem[wr_addr] <= q_head.pixel;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cur_w_reg     <= DIM_W'(MAX_WIDTH);
            cur_h_reg     <= HDIM_W'(MAX_HEIGHT);
            cur_half_reg  <= '0;
            cur_div_reg   <= DIVR_W'(1);
            tcol_reg      <= '0;
            trow_reg      <= '0;
            tring_reg     <= '0;
            gcol_reg      <= '0;
            grow_reg      <= '0;
            gring_reg     <= '0;
            di_reg        <= '0;
            dj_reg        <= '0;
            rring_reg     <= '0;
            rd_vld_reg    <= 1'b0;
            rd_ok_reg     <= 1'b0;
            acc_reg       <= '0;
            rem_reg       <= '0;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
            mean_reg      <= '0;
            last_reg      <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            rd_vld_reg <= (state_reg == ST_READ);
            if (rd_vld_reg)
            begin
                acc_reg <= acc_reg + (rd_ok_reg ? SUM_W'(rd_data_reg) : SUM_W'(0));
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (pop)
                    begin
                        cur_w_reg    <= eff_w;
                        cur_h_reg    <= eff_h;
                        cur_half_reg <= eff_half;
                        cur_div_reg  <= DIVR_W'(eff_side) * DIVR_W'(eff_side);
                        if (do_write)
                        begin
                            if ((DIM_W)'(tcol_reg) == eff_w - 1'b1)
                            begin
                                tcol_reg  <= '0;
                                trow_reg  <= trow_reg + 1'b1;
                                tring_reg <= (32'(tring_reg) == LR - 1) ?
                                             '0 : tring_reg + 1'b1;
                            end
                            else
                            begin
                                tcol_reg <= tcol_reg + 1'b1;
                            end
                        end
                        state_reg <= ST_CHECK;
                    end
                end
                ST_CHECK:
                begin
                    if (emit)
                    begin
                        di_reg    <= '0;
                        dj_reg    <= '0;
                        rring_reg <= RING_W'((32'(ring_start) >= LR) ?
                                             32'(ring_start) - LR : 32'(ring_start));
                        acc_reg   <= '0;
                        state_reg <= ST_READ;
                    end
                    else
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_READ:
                begin
                    rd_ok_reg  <= nb_ok;
                    if (dj_reg == side_m1)
                    begin
                        dj_reg    <= '0;
                        di_reg    <= di_reg + 1'b1;
                        rring_reg <= (32'(rring_reg) == LR - 1) ? '0 : rring_reg + 1'b1;
                        if (di_reg == side_m1)
                        begin
                            state_reg <= ST_DRAIN;
                        end
                    end
                    else
                    begin
                        dj_reg <= dj_reg + 1'b1;
                    end
                end
                ST_DRAIN:
                begin
                    rem_reg   <= '0;
                    step_reg  <= '0;
                    state_reg <= ST_DIV;
                end
                ST_DIV:
                begin
                    if (32'(step_reg) == SUM_W)
                    begin
                        out_valid_reg <= 1'b1;
                        mean_reg      <= acc_reg[PIX_W-1:0];
                        last_reg      <= is_last;
                        if (is_last)
                        begin
                            tcol_reg  <= '0;
                            trow_reg  <= '0;
                            tring_reg <= '0;
                            gcol_reg  <= '0;
                            grow_reg  <= '0;
                            gring_reg <= '0;
                        end
                        else if ((DIM_W+1)'(gcol_reg) == (DIM_W+1)'(cur_w_reg - 1'b1))
                        begin
                            gcol_reg  <= '0;
                            grow_reg  <= grow_reg + 1'b1;
                            gring_reg <= (32'(gring_reg) == LR - 1) ? '0 : gring_reg + 1'b1;
                        end
                        else
                        begin
                            gcol_reg <= gcol_reg + 1'b1;
                        end
                        state_reg <= ST_IDLE;
                    end
                    else
                    begin
                        step_reg <= step_reg + 1'b1;
                        if (shifted >= (DIVR_W+1)'(cur_div_reg))
                        begin
                            rem_reg <= shifted - (DIVR_W+1)'(cur_div_reg);
                            acc_reg <= {acc_reg[SUM_W-2:0], 1'b1};
                        end
                        else
                        begin
                            rem_reg <= shifted;
                            acc_reg <= {acc_reg[SUM_W-2:0], 1'b0};
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign out_valid  = out_valid_reg;
    assign mean_pixel = mean_reg;
    assign frame_last = last_reg;

endmodule

/* hdl/box_mean_filter.sv */
// A request that completes a window goes from the queue through the check, window
// read, drain and divide states before its result shows; one that completes none
// goes from the check state back to idle. A new request is taken only in idle and
// once any earlier result has been taken; the single line store read port and the
// bit-per-cycle divider (SUM_W = 14 bits at the default sizes) set the engine's pace.
// Reset (rst_n, asynchronous, active low) clears counters, queue, output and config registers, not the line store.
module box_mean_filter #(
    parameter int MAX_KERNEL = bmf_pkg::DEF_MAX_KERNEL,
    parameter int MAX_WIDTH  = bmf_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = bmf_pkg::DEF_MAX_HEIGHT
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [bmf_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [bmf_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic                              req_type,
    input  logic [bmf_pkg::PIX_W-1:0]         pixel_in,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [bmf_pkg::PIX_W-1:0]         mean_pixel,
    output logic                              frame_last
);
    import bmf_pkg::*;

    // Configuration registers. Writes are always taken; the engine samples
    // them only when a new frame begins. The line store holds no defined
    // contents after reset and needs no clearing pass.
    cfg_t cfg_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.kernel_size  <= KSIZE_RESET;
            cfg_reg.frame_width  <= WIDTH_RESET;
            cfg_reg.frame_height <= HEIGHT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_KERNEL_SIZE:  cfg_reg.kernel_size  <= cfg_data[KSIZE_W-1:0];
                CFG_FRAME_WIDTH:  cfg_reg.frame_width  <= cfg_data[CFG_DIM_W-1:0];
                CFG_FRAME_HEIGHT: cfg_reg.frame_height <= cfg_data[CFG_DIM_W-1:0];
                default:          cfg_reg <= cfg_reg;
            endcase
        end
    end

    // The front queue takes requests while the engine works on an earlier one.
    req_t in_req;
    req_t q_head;
    logic q_valid;
    logic q_pop;

    assign in_req.req_type = req_type;
    assign in_req.pixel    = pixel_in;

    bmf_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_req   (in_req),
        .q_valid  (q_valid),
        .q_head   (q_head),
        .q_pop    (q_pop)
    );

    // The engine stores pixels, sums each window one read per cycle and
    // divides by the window area one quotient bit per cycle.
    bmf_back #(
        .MAX_KERNEL (MAX_KERNEL),
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .q_valid    (q_valid),
        .q_head     (q_head),
        .q_pop      (q_pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .mean_pixel (mean_pixel),
        .frame_last (frame_last)
    );

endmodule

/* hdl/bmf_checker.sv */
module bmf_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       cfg_valid,
    input logic       cfg_ready,
    input logic       out_valid,
    input logic       out_stall,
    input logic [7:0] mean_pixel,
    input logic       frame_last
);

    // A held result keeps its value.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(mean_pixel) && $stable(frame_last))
        else $error("held result changed");

    // Work starts only once no result is held, so results never come back to back.
    a_no_b2b: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall |=> !out_valid)
        else $error("result followed a taken result at once");

    // Register writes are never refused.
    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("register write refused");

    // No result appears right after reset.
    a_reset_quiet: assert property (@(posedge clk)
        $rose(rst_n) |-> !out_valid)
        else $error("result present after reset");

endmodule

bind box_mean_filter bmf_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .mean_pixel (mean_pixel),
    .frame_last (frame_last)
);
